/* hdl/blir_pkg.sv */
// Shared types and constants for the bounded list block.
`default_nettype none

package blir_pkg;

	// Fixed widths of the item and result fields
	localparam int OP_BITS       = 3;
	localparam int INDEX_BITS    = 5;
	localparam int VALUE_BITS    = 32;
	localparam int READ_BITS     = 32;
	localparam int FILL_BITS     = 5;
	localparam int STATUS_BITS   = 2;
	localparam int MAX_ENTRY_BITS = 64;

	typedef enum logic [OP_BITS-1:0] {
		OP_PUSH      = 3'd0,
		OP_POP       = 3'd1,
		OP_INSERT    = 3'd2,
		OP_REMOVE    = 3'd3,
		OP_READ_AT   = 3'd4,
		OP_READ_TAIL = 3'd5,
		OP_CLEAR     = 3'd6
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic shift_up;
		logic shift_down;
		logic write;
	} cell_cmd_t;

endpackage

`default_nettype wire

/* hdl/blir_cell.sv */
// One storage cell of the list row: load, take from the lower or upper neighbor, or hold.
`default_nettype none

module blir_cell
	import blir_pkg::*;
#(
	parameter int ENTRY_BITS = 32,
	parameter int CW         = 5,
	parameter int POS        = 0
) (
	input  wire logic                  clk,
	input  wire cell_cmd_t             cmd,
	input  wire logic [CW-1:0]         lo,
	input  wire logic [CW-1:0]         hi,
	input  wire logic [CW-1:0]         wr_pos,
	input  wire logic [ENTRY_BITS-1:0] wr_data,
	input  wire logic [ENTRY_BITS-1:0] below,
	input  wire logic [ENTRY_BITS-1:0] above,
	output logic      [ENTRY_BITS-1:0] data_q
);

	localparam logic [CW-1:0] POS_C = CW'(POS);

	logic in_rng;

	// Shift window is lo <= POS < hi
	assign in_rng = (POS_C >= lo) && (POS_C < hi);

	always_ff @(posedge clk) begin
		if (cmd.write && (POS_C == wr_pos)) begin
			data_q <= wr_data;
		end else if (cmd.shift_up && in_rng) begin
			data_q <= below;
		end else if (cmd.shift_down && in_rng) begin
			data_q <= above;
		end
	end

endmodule

`default_nettype wire

/* hdl/blir_ctrl.sv */
// Operation decode: bounds checks, next fill count and the command for the cell row.
`default_nettype none

module blir_ctrl
	import blir_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  wire logic [OP_BITS-1:0]    op,
	input  wire logic [INDEX_BITS-1:0] index,
	input  wire logic                  has_value,
	input  wire logic                  go,
	input  wire logic [CW-1:0]         count,
	output cell_cmd_t                  cmd,
	output logic      [CW-1:0]         lo,
	output logic      [CW-1:0]         hi,
	output logic      [CW-1:0]         wr_pos,
	output logic                       rd_en,
	output logic      [CW-1:0]         rd_pos,
	output logic      [CW-1:0]         count_n,
	output status_t                    status
);

	localparam int CMPW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic [CMPW-1:0] idx_x;
	logic [CMPW-1:0] cnt_x;
	logic [CW-1:0]   idx_c;
	logic            full;
	logic            empty;
	cell_cmd_t       cmd_raw;

	assign idx_x = CMPW'(index);
	assign cnt_x = CMPW'(count);
	// Only used once idx is known to be no larger than count
	assign idx_c = idx_x[CW-1:0];
	assign full  = (count == DEPTH_C);
	assign empty = (count == '0);

	always_comb begin
		cmd_raw = '0;
		lo      = '0;
		hi      = '0;
		wr_pos  = '0;
		rd_en   = 1'b0;
		rd_pos  = '0;
		count_n = count;
		status  = ST_OK;
		case (op_t'(op))
			OP_PUSH: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					cmd_raw.write = has_value;
					wr_pos        = count;
					count_n       = count + ONE_C;
				end
			end
			OP_POP: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_n = count - ONE_C;
				end
			end
			OP_INSERT: begin
				if (idx_x > cnt_x) begin
					status = ST_RANGE;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					cmd_raw.shift_up = 1'b1;
					cmd_raw.write    = has_value;
					lo               = idx_c + ONE_C;
					hi               = count + ONE_C;
					wr_pos           = idx_c;
					count_n          = count + ONE_C;
				end
			end
			OP_REMOVE: begin
				if (idx_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					cmd_raw.shift_down = 1'b1;
					lo                 = idx_c;
					hi                 = count - ONE_C;
					count_n            = count - ONE_C;
				end
			end
			OP_READ_AT: begin
				if (idx_x >= cnt_x) begin
					status = ST_RANGE;
				end else begin
					rd_en  = 1'b1;
					rd_pos = idx_c;
				end
			end
			OP_READ_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					rd_en  = 1'b1;
					rd_pos = count - ONE_C;
				end
			end
			OP_CLEAR: begin
				count_n = '0;
			end
			default: begin
			end
		endcase
	end

	// Cells move only on an accepted transaction
	assign cmd = go ? cmd_raw : '0;

endmodule

`default_nettype wire

/* hdl/bounded_list_insert_remove.sv */
// Top level of the bounded list: cell row, fill count, decode and result register.
`default_nettype none

// Bounded ordered list of DEPTH entries of ENTRY_BITS each, held in a row of
// cells with a fill count. Each transaction on the item channel carries one
// operation (push, pop, insert at a position, remove at a position, read at a
// position, read of the tail, clear) and yields exactly one result
// transaction with read_data, the fill count after the operation and a
// status. The block takes one item every clock cycle while item_stall is
// low: every cell compares its own position against the broadcast bounds
// and loads, shifts from a neighbor or holds at the accepting edge, so an
// insert or remove of any length completes at that edge. The result is
// loaded into the output register at the accepting edge and may wait there;
// a new item is accepted in the same cycle the waiting result is taken. A
// failed operation reports full, empty or index out of range and leaves the
// list as it was. An insert or push with has_value low takes the slot
// without writing it. Entries are not cleared by reset; reading a slot never
// written since reset returns undefined data. No clearing pass runs after reset.

module bounded_list_insert_remove
	import blir_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int ENTRY_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// item channel
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire logic [OP_BITS-1:0]     op,
	input  wire logic [INDEX_BITS-1:0]  index,
	input  wire logic [VALUE_BITS-1:0]  value,
	input  wire logic                   has_value,
	// result channel
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic      [READ_BITS-1:0]   read_data,
	output logic      [FILL_BITS-1:0]   fill_count,
	output logic      [STATUS_BITS-1:0] status
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > FILL_BITS) ? CW : FILL_BITS;

	logic                  accept;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_n;
	cell_cmd_t             cmd;
	logic [CW-1:0]         lo;
	logic [CW-1:0]         hi;
	logic [CW-1:0]         wr_pos;
	logic                  rd_en;
	logic [CW-1:0]         rd_pos;
	status_t               status_n;
	logic [MAX_ENTRY_BITS-1:0] val_wide;
	logic [ENTRY_BITS-1:0] wr_data;
	logic [ENTRY_BITS-1:0] cell_data [DEPTH];
	logic [ENTRY_BITS-1:0] rd_entry;
	logic [MAX_ENTRY_BITS-1:0] rd_wide;
	logic [CMPW-1:0]       cnt_wide;

	logic                  res_valid_q;
	logic [READ_BITS-1:0]  read_data_q;
	logic [FILL_BITS-1:0]  fill_count_q;
	status_t               status_q;

	// Accept whenever the result register is empty or drains this cycle
	assign item_stall = res_valid_q && result_stall;
	assign accept     = item_valid && !item_stall;

	blir_ctrl #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_ctrl (
		.op        (op),
		.index     (index),
		.has_value (has_value),
		.go        (accept),
		.count     (count_q),
		.cmd       (cmd),
		.lo        (lo),
		.hi        (hi),
		.wr_pos    (wr_pos),
		.rd_en     (rd_en),
		.rd_pos    (rd_pos),
		.count_n   (count_n),
		.status    (status_n)
	);

	// Fit the 32-bit value to the entry width
	assign val_wide = MAX_ENTRY_BITS'(value);
	assign wr_data  = val_wide[ENTRY_BITS-1:0];

	// Row of cells; each end cell feeds itself where no neighbor exists
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_BITS-1:0] below;
		logic [ENTRY_BITS-1:0] above;

		if (i == 0) begin : g_first
			assign below = cell_data[i];
		end else begin : g_mid_lo
			assign below = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign above = cell_data[i];
		end else begin : g_mid_hi
			assign above = cell_data[i+1];
		end

		blir_cell #(
			.ENTRY_BITS (ENTRY_BITS),
			.CW         (CW),
			.POS        (i)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.lo      (lo),
			.hi      (hi),
			.wr_pos  (wr_pos),
			.wr_data (wr_data),
			.below   (below),
			.above   (above),
			.data_q  (cell_data[i])
		);
	end

	// Read: each cell gates its data by a position match, then OR them together
	always_comb begin
		rd_entry = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rd_en && (rd_pos == CW'(i))) begin
				rd_entry = rd_entry | cell_data[i];
			end
		end
	end

	assign rd_wide  = MAX_ENTRY_BITS'(rd_entry);
	assign cnt_wide = CMPW'(count_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload: load on accept, hold otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q  <= rd_wide[READ_BITS-1:0];
			fill_count_q <= cnt_wide[FILL_BITS-1:0];
			status_q     <= status_n;
		end
	end

	assign result_valid = res_valid_q;
	assign read_data    = read_data_q;
	assign fill_count   = fill_count_q;
	assign status       = status_q;

	// Fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above capacity");

	// Every accepted transaction leaves a result waiting
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted item produced no result");

	// A failed operation leaves the count unchanged
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (status_n != ST_OK)) |=> (count_q == $past(count_q)))
		else $error("failed operation changed the fill count");

	// Reported fill count matches the count register after acceptance
	a_fill_match: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (fill_count_q == FILL_BITS'(count_q)))
		else $error("reported fill count differs from count register");

	// Stall toward the item side only while a result waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> res_valid_q)
		else $error("item stall without a waiting result");

endmodule

`default_nettype wire

/* tb/bounded_list_insert_remove_tb.sv */
// Self-checking testbench for the bounded list with insert and remove by position.
`default_nettype none

module bounded_list_insert_remove_tb
	import blir_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH   = 16;
	localparam int RANDOM_ITEMS = 1500;
	localparam int DRAIN_EVERY  = 300;
	// Op code outside the defined set; the block must ignore it
	localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;

	// One result transaction as the block reports it
	typedef struct packed {
		logic [READ_BITS-1:0]   rd;
		logic [FILL_BITS-1:0]   fill;
		status_t                st;
	} list_result_t;

	// One row of the corner-case table; reps repeats the item, and fixed_exp marks
	// rows whose result is typed in rather than taken from the list predictor
	typedef struct packed {
		logic [OP_BITS-1:0]     op;
		logic [INDEX_BITS-1:0]  idx;
		logic [VALUE_BITS-1:0]  val;
		logic                   hv;
		logic [4:0]             reps;
		logic                   fixed_exp;
		list_result_t           exp;
	} stim_row_t;

	localparam int CORNER_COUNT = 27;
	localparam stim_row_t CORNER_ROWS [CORNER_COUNT] = '{
		// empty list: every access fails
		'{OP_READ_TAIL, 5'd0,  32'h0,        1'b0, 5'd1,  1'b1, '{32'h0, 5'd0, ST_EMPTY}},
		'{OP_POP,       5'd0,  32'h0,        1'b0, 5'd1,  1'b1, '{32'h0, 5'd0, ST_EMPTY}},
		'{OP_READ_AT,   5'd0,  32'h0,        1'b0, 5'd1,  1'b1, '{32'h0, 5'd0, ST_RANGE}},
		'{OP_REMOVE,    5'd0,  32'h0,        1'b0, 5'd1,  1'b1, '{32'h0, 5'd0, ST_RANGE}},
		'{OP_INSERT,    5'd1,  32'hDEADBEEF, 1'b1, 5'd1,  1'b1, '{32'h0, 5'd0, ST_RANGE}},
		// build a short list with extreme values, inserting at head and at count
		'{OP_PUSH,      5'd0,  32'hFFFFFFFF, 1'b1, 5'd1,  1'b1, '{32'h0, 5'd1, ST_OK}},
		'{OP_INSERT,    5'd0,  32'h0,        1'b1, 5'd1,  1'b1, '{32'h0, 5'd2, ST_OK}},
		'{OP_INSERT,    5'd2,  32'hA5A5A5A5, 1'b1, 5'd1,  1'b1, '{32'h0, 5'd3, ST_OK}},
		'{OP_READ_AT,   5'd0,  32'h0,        1'b0, 5'd1,  1'b1, '{32'h0, 5'd3, ST_OK}},
		'{OP_READ_AT,   5'd1,  32'h0,        1'b0, 5'd1,  1'b1, '{32'hFFFFFFFF, 5'd3, ST_OK}},
		'{OP_READ_TAIL, 5'd0,  32'h0,        1'b0, 5'd1,  1'b1, '{32'hA5A5A5A5, 5'd3, ST_OK}},
		'{OP_UNUSED,    5'd31, 32'hFFFFFFFF, 1'b1, 5'd1,  1'b1, '{32'h0, 5'd3, ST_OK}},
		// insert without a value keeps the copy of the shifted entry
		'{OP_INSERT,    5'd1,  32'h12345678, 1'b0, 5'd1,  1'b0, '0},
		'{OP_READ_AT,   5'd1,  32'h0,        1'b0, 5'd1,  1'b0, '0},
		'{OP_REMOVE,    5'd0,  32'h0,        1'b0, 5'd1,  1'b0, '0},
		'{OP_READ_AT,   5'd31, 32'h0,        1'b0, 5'd1,  1'b1, '{32'h0, 5'd3, ST_RANGE}},
		'{OP_CLEAR,     5'd0,  32'h0,        1'b0, 5'd1,  1'b1, '{32'h0, 5'd0, ST_OK}},
		// push without a value exposes the old tail cell
		'{OP_PUSH,      5'd0,  32'h0,        1'b0, 5'd1,  1'b0, '0},
		'{OP_READ_TAIL, 5'd0,  32'h0,        1'b0, 5'd1,  1'b0, '0},
		// fill to capacity, then hit the full and range checks
		'{OP_PUSH,      5'd0,  32'h5A5A5A5A, 1'b1, 5'd15, 1'b0, '0},
		'{OP_PUSH,      5'd0,  32'h0,        1'b1, 5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
		'{OP_INSERT,    5'd16, 32'h0,        1'b1, 5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
		'{OP_INSERT,    5'd17, 32'h0,        1'b1, 5'd1,  1'b1, '{32'h0, 5'd16, ST_RANGE}},
		'{OP_READ_AT,   5'd15, 32'h0,        1'b0, 5'd1,  1'b0, '0},
		'{OP_REMOVE,    5'd7,  32'h0,        1'b0, 5'd1,  1'b0, '0},
		'{OP_POP,       5'd0,  32'h0,        1'b0, 5'd1,  1'b0, '0},
		'{OP_READ_TAIL, 5'd0,  32'h0,        1'b0, 5'd1,  1'b0, '0}
	};

	// DUT ports; every input starts at a known value
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	logic [OP_BITS-1:0]     op = '0;
	logic [INDEX_BITS-1:0]  index = '0;
	logic [VALUE_BITS-1:0]  value = '0;
	logic                   has_value = 1'b0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [READ_BITS-1:0]   read_data;
	logic [FILL_BITS-1:0]   fill_count;
	logic [STATUS_BITS-1:0] status;

	// Predictor state: cell contents, which cells ever got data, and the count
	logic [VALUE_BITS-1:0]  list_cells [LIST_DEPTH];
	bit                     cell_written [LIST_DEPTH];
	int                     list_count = 0;

	list_result_t           expected_results [$];
	int                     mismatch_count = 0;
	int                     results_seen = 0;
	int                     items_sent = 0;
	int                     status_hits [4] = '{0, 0, 0, 0};
	int                     burst_left = 0;

	bounded_list_insert_remove #(
		.DEPTH      (LIST_DEPTH),
		.ENTRY_BITS (VALUE_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.index        (index),
		.value        (value),
		.has_value    (has_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.read_data    (read_data),
		.fill_count   (fill_count),
		.status       (status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: the slowest legal run needs well under a tenth of this
	initial begin
		#5_000_000;
		$display("bounded_list_insert_remove test failed");
		$finish;
	end

	// Apply one operation to the predicted list and return the result it should give.
	// A failing operation leaves cells and count alone and reads back zero.
	function automatic void list_apply(input logic [OP_BITS-1:0] c_op,
		input logic [INDEX_BITS-1:0] c_idx, input logic [VALUE_BITS-1:0] c_val,
		input logic c_hv, output list_result_t res);
		int i;
		res.rd = '0;
		res.st = ST_OK;
		case (c_op)
			OP_PUSH: begin
				if (list_count >= LIST_DEPTH) begin
					res.st = ST_FULL;
				end else begin
					if (c_hv) begin
						list_cells[list_count] = c_val;
						cell_written[list_count] = 1'b1;
					end
					list_count++;
				end
			end
			OP_POP: begin
				if (list_count == 0)
					res.st = ST_EMPTY;
				else
					list_count--;
			end
			OP_INSERT: begin
				// range is checked ahead of fullness
				if (c_idx > list_count) begin
					res.st = ST_RANGE;
				end else if (list_count >= LIST_DEPTH) begin
					res.st = ST_FULL;
				end else begin
					for (i = list_count; i > c_idx; i--) begin
						list_cells[i] = list_cells[i-1];
						cell_written[i] = cell_written[i-1];
					end
					if (c_hv) begin
						list_cells[c_idx] = c_val;
						cell_written[c_idx] = 1'b1;
					end
					list_count++;
				end
			end
			OP_REMOVE: begin
				if (c_idx >= list_count) begin
					res.st = ST_RANGE;
				end else begin
					// the old tail cell keeps its contents
					for (i = c_idx; i + 1 < list_count; i++) begin
						list_cells[i] = list_cells[i+1];
						cell_written[i] = cell_written[i+1];
					end
					list_count--;
				end
			end
			OP_READ_AT: begin
				if (c_idx >= list_count)
					res.st = ST_RANGE;
				else
					res.rd = list_cells[c_idx];
			end
			OP_READ_TAIL: begin
				if (list_count == 0)
					res.st = ST_EMPTY;
				else
					res.rd = list_cells[list_count-1];
			end
			OP_CLEAR: begin
				list_count = 0;
			end
			default: begin
			end
		endcase
		res.fill = list_count[FILL_BITS-1:0];
	endfunction

	// Present one item and hold it until the block takes it. The sender runs in
	// bursts; between bursts drop valid for a random gap, sometimes none at all.
	task automatic send_item(input logic [OP_BITS-1:0] s_op,
		input logic [INDEX_BITS-1:0] s_idx, input logic [VALUE_BITS-1:0] s_val,
		input logic s_hv, input logic use_fixed, input list_result_t fixed_res);
		list_result_t predicted;
		int gap;
		list_apply(s_op, s_idx, s_val, s_hv, predicted);
		if (use_fixed)
			predicted = fixed_res;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op <= s_op;
		index <= s_idx;
		value <= s_val;
		has_value <= s_hv;
		// hold the payload steady while stalled
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		expected_results.push_back(predicted);
		status_hits[predicted.st]++;
		items_sent++;
	endtask

	task automatic report_mismatch(input string what, input list_result_t want);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected read_data %h fill %0d status %0d, got %h %0d %0d",
				$time, what, want.rd, want.fill, want.st, read_data, fill_count, status);
	endtask

	// Receiver: switch every so often between no stalls, light and heavy random
	// stalls, and long stall runs
	always @(posedge clk) begin
		static int cycle_ctr = 0;
		static int stall_mode = 0;
		static int stall_run = 0;
		cycle_ctr++;
		if (cycle_ctr % 97 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 4) < 3);
			default: begin
				if (stall_run > 0) begin
					stall_run--;
					result_stall <= 1'b1;
				end else if ($urandom_range(0, 5) == 0) begin
					stall_run = $urandom_range(2, 8);
					result_stall <= 1'b1;
				end else begin
					result_stall <= 1'b0;
				end
			end
		endcase
	end

	// Result checker: match each taken result against the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no transaction outstanding", '0);
			end else begin
				want = expected_results.pop_front();
				if (read_data !== want.rd || fill_count !== want.fill || status !== want.st)
					report_mismatch("result mismatch", want);
			end
		end
	end

	initial begin : stimulus
		stim_row_t row;
		logic [OP_BITS-1:0] r_op;
		logic [INDEX_BITS-1:0] r_idx;
		logic [VALUE_BITS-1:0] r_val;
		logic r_hv;
		int roll;
		int r;
		int n;
		bit grow_phase;

		grow_phase = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases from the table
		for (r = 0; r < CORNER_COUNT; r++) begin
			row = CORNER_ROWS[r];
			repeat (row.reps)
				send_item(row.op, row.idx, row.val, row.hv, row.fixed_exp, row.exp);
		end

		// Random traffic in grow and shrink phases so the list keeps running from
		// empty to full and back
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// pause now and then until every result is back
			if (n % DRAIN_EVERY == 0) begin
				item_valid <= 1'b0;
				while (expected_results.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(0, 39) == 0)
				grow_phase = !grow_phase;
			roll = $urandom_range(0, 99);
			if (roll < 2)
				r_op = OP_CLEAR;
			else if (roll < 4)
				r_op = OP_UNUSED;
			else if (roll < 27)
				r_op = OP_READ_AT;
			else if (roll < 35)
				r_op = OP_READ_TAIL;
			else if (roll < 67)
				r_op = grow_phase ? OP_PUSH : OP_POP;
			else if (roll < 94)
				r_op = grow_phase ? OP_INSERT : OP_REMOVE;
			else if (roll < 97)
				r_op = grow_phase ? OP_POP : OP_PUSH;
			else
				r_op = grow_phase ? OP_REMOVE : OP_INSERT;

			// mostly positions near the live range, sometimes anywhere in the field
			if ($urandom_range(0, 3) != 0)
				r_idx = INDEX_BITS'($urandom_range(0, list_count));
			else
				r_idx = INDEX_BITS'($urandom_range(0, 31));

			roll = $urandom_range(0, 9);
			if (roll == 0)
				r_val = '0;
			else if (roll == 1)
				r_val = '1;
			else
				r_val = $urandom;
			r_hv = ($urandom_range(0, 4) != 0);

			// never read a cell that has held no data since reset; turn such a
			// read into an out-of-range read instead
			if (r_op == OP_READ_TAIL && list_count != 0 && !cell_written[list_count-1]) begin
				r_op = OP_READ_AT;
				r_idx = INDEX_BITS'(list_count);
			end
			if (r_op == OP_READ_AT && r_idx < list_count && !cell_written[r_idx])
				r_idx = INDEX_BITS'(list_count);

			send_item(r_op, r_idx, r_val, r_hv, 1'b0, '0);
		end

		// Drain, then let the pipeline settle before the last check
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0d expected results never arrived", expected_results.size());
			mismatch_count += expected_results.size();
		end

		$display("Sent %0d transactions, checked %0d results: ok %0d, full %0d, empty %0d, range %0d.",
			items_sent, results_seen, status_hits[ST_OK], status_hits[ST_FULL],
			status_hits[ST_EMPTY], status_hits[ST_RANGE]);
		$display("Covered corner cases, unwritten slots, unused op and bursty grow/shrink traffic.");
		if (mismatch_count == 0)
			$display("bounded_list_insert_remove test passed");
		else
			$display("bounded_list_insert_remove test failed");
		$finish;
	end

endmodule

`default_nettype wire
